FILE: rtl/crm_pkg.sv
package crm_pkg;

   // elaboration defaults
   localparam int PATTERN_BYTES_DEFAULT = 16;
   localparam int RESP_CAPACITY_DEFAULT = 512;
   localparam int QUEUE_DEPTH           = 2;

   localparam int LEN_W   = 5;
   localparam int TICK_W  = 32;
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;

   // item kinds on the request side
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // classified operations handed from front to back
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   // verdict codes
   localparam logic [2:0] VERDICT_NONE     = 3'd0;
   localparam logic [2:0] VERDICT_PAT_ONE  = 3'd1;
   localparam logic [2:0] VERDICT_PAT_TWO  = 3'd2;
   localparam logic [2:0] VERDICT_ERR_TEXT = 3'd3;
   localparam logic [2:0] VERDICT_OVERFLOW = 3'd4;
   localparam logic [2:0] VERDICT_TIMEOUT  = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_P1_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_P1_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_P1_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P2_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_P2_HIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_P2_LEN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIM = 3'd6;

   localparam logic [TICK_W-1:0] WAIT_LIMIT_RESET = 32'd1000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic       waiting;
   } rsp_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } op_type;

   typedef struct packed {
      logic [63:0]       pattern_one_low;
      logic [63:0]       pattern_one_high;
      logic [LEN_W-1:0]  pattern_one_length;
      logic [63:0]       pattern_two_low;
      logic [63:0]       pattern_two_high;
      logic [LEN_W-1:0]  pattern_two_length;
      logic [TICK_W-1:0] wait_limit_ticks;
   } cfg_type;

endpackage

FILE: rtl/command_response_matcher_unit.sv
// Command/response matcher: one result beat per request beat, in order.
// Throughput: one request beat per cycle while the result queue has room; the byte compare
// over the whole pattern history and the tick count/compare are combinational in the back end.
// A request beat passes through the op queue and then the result queue before it shows on rsp_data.
// Reset (synchronous, active high) empties both queues, disarms the wait,
// clears the counters and loads the register reset values (wait limit 1000).
module command_response_matcher_unit #(
   parameter int PATTERN_BYTES = crm_pkg::PATTERN_BYTES_DEFAULT,
   parameter int RESP_CAPACITY = crm_pkg::RESP_CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request beats
   input  logic                             req_push,
   input  crm_pkg::req_type                 req_data,
   output logic                             req_full,
   // result beats
   input  logic                             rsp_pop,
   output crm_pkg::rsp_type                 rsp_data,
   output logic                             rsp_empty,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [crm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [crm_pkg::CSR_W-1:0]        csr_wdata
);
   import crm_pkg::*;

   // register values after reset: everything zero except the wait limit
   localparam cfg_type CFG_RESET = '{
      pattern_one_low:    64'd0,
      pattern_one_high:   64'd0,
      pattern_one_length: {LEN_W{1'b0}},
      pattern_two_low:    64'd0,
      pattern_two_high:   64'd0,
      pattern_two_length: {LEN_W{1'b0}},
      wait_limit_ticks:   WAIT_LIMIT_RESET
   };

   cfg_type cfg_ff, cfg_in;
   op_type  op_data;
   logic    op_pop;
   logic    op_empty;

   // Registers are always writable; the back end reads them directly,
   // so a write lands before any later request beat is processed.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_P1_LOW:   cfg_in.pattern_one_low    = csr_wdata;
            CSR_P1_HIGH:  cfg_in.pattern_one_high   = csr_wdata;
            CSR_P1_LEN:   cfg_in.pattern_one_length = csr_wdata[LEN_W-1:0];
            CSR_P2_LOW:   cfg_in.pattern_two_low    = csr_wdata;
            CSR_P2_HIGH:  cfg_in.pattern_two_high   = csr_wdata;
            CSR_P2_LEN:   cfg_in.pattern_two_length = csr_wdata[LEN_W-1:0];
            CSR_WAIT_LIM: cfg_in.wait_limit_ticks   = csr_wdata[TICK_W-1:0];
            default: begin
               // writes past the register list are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: takes request beats, classifies the kind, queues the op.
   crm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_pop   (op_pop),
      .op_data  (op_data),
      .op_empty (op_empty)
   );

   // Back end: owns the wait state, history and counters, does the
   // pattern/text/timeout checks and queues one result beat per op.
   crm_back #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .RESP_CAPACITY (RESP_CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_empty  (op_empty),
      .op_data   (op_data),
      .op_pop    (op_pop),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

endmodule

FILE: rtl/crm_queue.sv
module crm_queue #(
   parameter int WIDTH = $bits(crm_pkg::op_type),
   parameter int DEPTH = crm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/crm_front.sv
module crm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  crm_pkg::req_type req_data,
   output logic             req_full,
   input  logic             op_pop,
   output crm_pkg::op_type  op_data,
   output logic             op_empty
);
   import crm_pkg::*;

   op_type                   op_cls;
   logic [$bits(op_type)-1:0] op_vec;

   // unused kind code becomes a no-op
   always_comb begin
      op_cls.rx_byte = req_data.rx_byte;
      unique case (req_data.kind)
         KIND_START: op_cls.op = OP_START;
         KIND_BYTE:  op_cls.op = OP_BYTE;
         KIND_TICK:  op_cls.op = OP_TICK;
         default:    op_cls.op = OP_NOP;
      endcase
   end

   crm_queue #(
      .WIDTH ($bits(op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (op_cls),
      .full      (req_full),
      .pop       (op_pop),
      .pop_data  (op_vec),
      .empty     (op_empty)
   );

   assign op_data = op_type'(op_vec);

endmodule

FILE: rtl/crm_back.sv
module crm_back #(
   parameter int PATTERN_BYTES = crm_pkg::PATTERN_BYTES_DEFAULT,
   parameter int RESP_CAPACITY = crm_pkg::RESP_CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  crm_pkg::cfg_type cfg,
   input  logic             op_empty,
   input  crm_pkg::op_type  op_data,
   output logic             op_pop,
   input  logic             rsp_pop,
   output crm_pkg::rsp_type rsp_data,
   output logic             rsp_empty
);
   import crm_pkg::*;

   localparam int SEEN_W = $clog2(RESP_CAPACITY);
   localparam int CMP_W  = (SEEN_W > LEN_W) ? SEEN_W : LEN_W;
   localparam logic [SEEN_W-1:0] SEEN_LAST = SEEN_W'(RESP_CAPACITY - 1);
   localparam logic [LEN_W-1:0]  PB_LEN    = LEN_W'(PATTERN_BYTES);
   localparam logic [39:0] TXT_ERROR  = "ERROR";
   localparam logic [31:0] TXT_FAIL   = "FAIL";
   localparam logic [47:0] TXT_CLOSED = "CLOSED";
   localparam logic [CMP_W-1:0] LEN_ERROR  = CMP_W'(5);
   localparam logic [CMP_W-1:0] LEN_FAIL   = CMP_W'(4);
   localparam logic [CMP_W-1:0] LEN_CLOSED = CMP_W'(6);

   // history entry j must equal pattern char (len-1-j) for every j < len; len capped at PATTERN_BYTES, nonzero, <= seen
   function automatic logic pattern_hit(
      input logic [PATTERN_BYTES-1:0][7:0] hist,
      input logic [SEEN_W-1:0]             seen,
      input logic [63:0]                   lo,
      input logic [63:0]                   hi,
      input logic [LEN_W-1:0]              len
   );
      logic [15:0][7:0]  txt;
      logic [LEN_W-1:0]  eff;
      logic [LEN_W-1:0]  idx;
      logic              hit;
      txt = {hi, lo};
      eff = (len > PB_LEN) ? PB_LEN : len;
      hit = (eff != '0) && (CMP_W'(seen) >= CMP_W'(eff));
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         idx = eff - LEN_W'(j) - LEN_W'(1);
         if ((LEN_W'(j) < eff) && (hist[j] != txt[idx[3:0]])) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   logic [PATTERN_BYTES-1:0][7:0] hist_ff, hist_in, hist_shift;
   logic [SEEN_W-1:0]             seen_ff, seen_in, seen_inc;
   logic [TICK_W-1:0]             ticks_ff, ticks_in, ticks_next;
   logic                          armed_ff, armed_in;
   logic                          hit_one, hit_two, hit_text;
   logic [2:0]                    verdict;
   rsp_type                       res_data;
   logic                          res_full;
   logic [$bits(rsp_type)-1:0]    rsp_vec;

   assign op_pop = !op_empty && !res_full;

   assign hist_shift = {hist_ff[PATTERN_BYTES-2:0], op_data.rx_byte};
   assign seen_inc   = seen_ff + SEEN_W'(1);
   assign ticks_next = (ticks_ff == '1) ? ticks_ff : ticks_ff + TICK_W'(1);

   assign hit_one = pattern_hit(hist_shift, seen_inc, cfg.pattern_one_low,
                                cfg.pattern_one_high, cfg.pattern_one_length);
   assign hit_two = pattern_hit(hist_shift, seen_inc, cfg.pattern_two_low,
                                cfg.pattern_two_high, cfg.pattern_two_length);
   assign hit_text =
      ((CMP_W'(seen_inc) >= LEN_ERROR)  && (hist_shift[4:0] == TXT_ERROR))  ||
      ((CMP_W'(seen_inc) >= LEN_FAIL)   && (hist_shift[3:0] == TXT_FAIL))   ||
      ((CMP_W'(seen_inc) >= LEN_CLOSED) && (hist_shift[5:0] == TXT_CLOSED));

   always_comb begin
      hist_in  = hist_ff;
      seen_in  = seen_ff;
      ticks_in = ticks_ff;
      armed_in = armed_ff;
      verdict  = VERDICT_NONE;
      if (op_pop) begin
         unique case (op_data.op)
            OP_START: begin
               hist_in  = '0;
               seen_in  = '0;
               ticks_in = '0;
               armed_in = (cfg.wait_limit_ticks != '0);
               if (cfg.wait_limit_ticks == '0) begin
                  verdict = VERDICT_TIMEOUT;
               end
            end
            OP_BYTE: begin
               if (armed_ff) begin
                  if (seen_ff >= SEEN_LAST) begin
                     verdict  = VERDICT_OVERFLOW;
                     armed_in = 1'b0;
                  end else begin
                     hist_in = hist_shift;
                     seen_in = seen_inc;
                     priority if (hit_one) begin
                        verdict = VERDICT_PAT_ONE;
                     end else if (hit_two) begin
                        verdict = VERDICT_PAT_TWO;
                     end else if (hit_text) begin
                        verdict = VERDICT_ERR_TEXT;
                     end else begin
                        verdict = VERDICT_NONE;
                     end
                     armed_in = !(hit_one || hit_two || hit_text);
                  end
               end
            end
            OP_TICK: begin
               if (armed_ff) begin
                  ticks_in = ticks_next;
                  if (ticks_next >= cfg.wait_limit_ticks) begin
                     verdict  = VERDICT_TIMEOUT;
                     armed_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      res_data.verdict = verdict;
      res_data.waiting = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         ticks_ff <= '0;
         armed_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         ticks_ff <= ticks_in;
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
   end

   crm_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_pop),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(rsp_vec);

`ifndef ASSERT_OFF
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_LAST)
      else $error("byte count beyond capacity");

   a_verdict_disarms: assert property (@(posedge clock) disable iff (reset)
      (op_pop && res_data.verdict != VERDICT_NONE) |=> !armed_ff)
      else $error("wait still armed after a verdict");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (op_pop && !armed_ff && (op_data.op == OP_BYTE || op_data.op == OP_TICK))
      |-> (res_data.verdict == VERDICT_NONE && !res_data.waiting))
      else $error("verdict while disarmed");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op_data.op == OP_START) |=> (seen_ff == '0 && ticks_ff == '0))
      else $error("start did not clear counters");
`endif

endmodule
